// File: src/bpfa_pkg.sv
`timescale 1ns / 1ps

package bpfa_pkg;

    // Geometry of the page map
    localparam int MAX_PAGE_COUNT = 1048576;
    localparam int PAGE_SHIFT     = 12;
    localparam int RESERVED_COUNT = 256;
    localparam int MAP_WORDS      = (MAX_PAGE_COUNT + 31) / 32;
    localparam int MAP_BITS       = MAP_WORDS * 32;
    localparam int WORD_AW        = $clog2(MAP_WORDS);
    localparam int PAGE_IDX_W     = WORD_AW + 5;
    localparam int CNT_W          = 21;
    localparam int RES_EFF        = (RESERVED_COUNT > MAP_BITS) ? MAP_BITS : RESERVED_COUNT;
    localparam int BASE_W         = CNT_W + 6;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request kinds
    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    typedef enum logic [2:0] {
        ST_DONE         = 3'd0,
        ST_OOM          = 3'd1,
        ST_RESERVED     = 3'd2,
        ST_RANGE        = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } status_t;

    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] addr;
        logic [31:0]        wdata;
    } map_req_t;

    typedef struct packed {
        logic [31:0]      addr;
        status_t          status;
        logic [CNT_W-1:0] free_count;
    } result_t;

    // Bits [0, n) set, n from 0 to 32
    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [31:0] m;
        if (n >= 6'd32)
        begin
            m = '1;
        end
        else
        begin
            m = (32'd1 << n) - 32'd1;
        end
        return m;
    endfunction

    // Index of the lowest set bit
    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // Map word written by init: free below page count, reserved pages used
    function automatic logic [31:0] init_word(input logic [WORD_AW-1:0] w,
                                              input logic [CNT_W-1:0]   pc);
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] pcw;
        logic [BASE_W-1:0] res;
        logic [31:0]       v;
        base = BASE_W'({w, 5'b0});
        pcw  = BASE_W'(pc);
        res  = BASE_W'(RES_EFF);
        if (pcw >= base + BASE_W'(32))
        begin
            v = '0;
        end
        else if (pcw <= base)
        begin
            v = '1;
        end
        else
        begin
            v = ~low_mask(6'(pcw - base));
        end
        if (res >= base + BASE_W'(32))
        begin
            v = '1;
        end
        else if (res > base)
        begin
            v = v | low_mask(6'(res - base));
        end
        return v;
    endfunction

endpackage

// File: src/bpfa_map_ram.sv
`timescale 1ns / 1ps

module bpfa_map_ram
    import bpfa_pkg::*;
(
    input  logic        clk,
    input  map_req_t    req,
    output logic [31:0] rdata
);

    logic [31:0] mem [MAP_WORDS];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

// File: src/bpfa_engine.sv
`timescale 1ns / 1ps

module bpfa_engine
    import bpfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] mem_size_bytes,
    input  logic [31:0] page_address,
    output logic        res_valid,
    input  logic        res_take,
    output result_t     res,
    output map_req_t    map_req,
    input  logic [31:0] map_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_FREE_CHK,
        S_DONE
    } state_t;

    state_t             state_reg,       state_next;
    logic [CNT_W-1:0]   page_count_reg,  page_count_next;
    logic [CNT_W-1:0]   used_count_reg,  used_count_next;
    logic [WORD_AW:0]   limit_reg,       limit_next;
    logic [WORD_AW:0]   hint_reg,        hint_next;
    logic [WORD_AW:0]   ptr_reg,         ptr_next;
    logic               chk_valid_reg,   chk_valid_next;
    logic [WORD_AW-1:0] chk_word_reg,    chk_word_next;
    logic [4:0]         bit_reg,         bit_next;
    logic [31:0]        res_addr_reg,    res_addr_next;
    status_t            res_status_reg,  res_status_next;

    logic [31:0]         page32;
    logic [31:0]         mem_pages;
    logic [CNT_W-1:0]    pc_new;
    logic [CNT_W:0]      pc_round;
    logic [BASE_W-1:0]   chk_base;
    logic [BASE_W-1:0]   chk_rem;
    logic [31:0]         valid_mask;
    logic [31:0]         free_bits;
    logic [4:0]          hit_bit;
    logic                hit;
    logic                issue;
    logic [PAGE_IDX_W-1:0] hit_page;

    // Decode request fields
    assign page32    = page_address >> PAGE_SHIFT;
    assign mem_pages = mem_size_bytes >> PAGE_SHIFT;
    assign pc_new    = (mem_pages > 32'(MAX_PAGE_COUNT)) ? CNT_W'(MAX_PAGE_COUNT)
                                                         : CNT_W'(mem_pages);
    assign pc_round  = (CNT_W + 1)'(pc_new) + (CNT_W + 1)'(31);

    // Examine the word returned by the map
    assign chk_base   = BASE_W'({chk_word_reg, 5'b0});
    assign chk_rem    = BASE_W'(page_count_reg) - chk_base;
    assign valid_mask = (chk_rem >= BASE_W'(32)) ? '1 : low_mask(6'(chk_rem));
    assign free_bits  = ~map_rdata & valid_mask;
    assign hit_bit    = lowest_set(free_bits);
    assign hit        = chk_valid_reg && (free_bits != '0);
    assign issue      = ptr_reg < limit_reg;
    assign hit_page   = {chk_word_reg, hit_bit};

    // Sequence one request through the map
    always_comb
    begin
        state_next      = state_reg;
        page_count_next = page_count_reg;
        used_count_next = used_count_reg;
        limit_next      = limit_reg;
        hint_next       = hint_reg;
        ptr_next        = ptr_reg;
        chk_valid_next  = chk_valid_reg;
        chk_word_next   = chk_word_reg;
        bit_next        = bit_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        map_req.we      = 1'b0;
        map_req.addr    = ptr_reg[WORD_AW-1:0];
        map_req.wdata   = init_word(ptr_reg[WORD_AW-1:0], page_count_reg);

        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                map_req.addr = page32[PAGE_IDX_W-1:5];
                if (in_valid)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_DONE;
                    case (kind)
                        KIND_INIT:
                        begin
                            page_count_next = pc_new;
                            used_count_next = CNT_W'(RESERVED_COUNT);
                            limit_next      = (WORD_AW + 1)'(pc_round >> 5);
                            hint_next       = '0;
                            ptr_next        = '0;
                            state_next      = S_INIT;
                        end
                        KIND_ALLOC:
                        begin
                            ptr_next       = hint_reg;
                            chk_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                        KIND_FREE:
                        begin
                            if (page32 < 32'(RESERVED_COUNT))
                            begin
                                res_status_next = ST_RESERVED;
                                state_next      = S_DONE;
                            end
                            else if (page32 >= 32'(page_count_reg))
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                chk_word_next = page32[PAGE_IDX_W-1:5];
                                bit_next      = page32[4:0];
                                state_next    = S_FREE_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Sweep the words below the page count
            S_INIT:
            begin
                if (issue)
                begin
                    map_req.we = 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Stream reads from the hint, check one word per cycle
            S_SCAN:
            begin
                if (hit)
                begin
                    map_req.we    = 1'b1;
                    map_req.addr  = chk_word_reg;
                    map_req.wdata = map_rdata | (32'd1 << hit_bit);
                    if (used_count_reg < CNT_MAX)
                    begin
                        used_count_next = used_count_reg + 1'b1;
                    end
                    hint_next     = {1'b0, chk_word_reg};
                    res_addr_next = 32'(hit_page) << PAGE_SHIFT;
                    state_next    = S_DONE;
                end
                else if (issue)
                begin
                    ptr_next       = ptr_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_word_next  = ptr_reg[WORD_AW-1:0];
                end
                else if (!chk_valid_reg)
                begin
                    res_status_next = ST_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end

            // Clear the used bit if it is set
            S_FREE_CHK:
            begin
                map_req.addr  = chk_word_reg;
                map_req.wdata = map_rdata & ~(32'd1 << bit_reg);
                if (!map_rdata[bit_reg])
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    map_req.we = 1'b1;
                    if (used_count_reg != '0)
                    begin
                        used_count_next = used_count_reg - 1'b1;
                    end
                    if ({1'b0, chk_word_reg} < hint_reg)
                    begin
                        hint_next = {1'b0, chk_word_reg};
                    end
                end
                state_next = S_DONE;
            end

            // Hold the result until the output register takes it
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.addr       = res_addr_reg;
    assign res.status     = res_status_reg;
    assign res.free_count = (page_count_reg > used_count_reg) ?
                            (page_count_reg - used_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            page_count_reg <= '0;
            used_count_reg <= '0;
            limit_reg      <= '0;
            hint_reg       <= '0;
            ptr_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            chk_word_reg   <= '0;
            bit_reg        <= '0;
            res_addr_reg   <= '0;
            res_status_reg <= ST_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            page_count_reg <= page_count_next;
            used_count_reg <= used_count_next;
            limit_reg      <= limit_next;
            hint_reg       <= hint_next;
            ptr_reg        <= ptr_next;
            chk_valid_reg  <= chk_valid_next;
            chk_word_reg   <= chk_word_next;
            bit_reg        <= bit_next;
            res_addr_reg   <= res_addr_next;
            res_status_reg <= res_status_next;
        end
    end

endmodule

// File: src/bitmap_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid / in_ready  kind, mem_size_bytes, page_address
// out      out_valid/ out_ready alloc_address, status, free_count
//
// Init writes ceil(pages / 32) map words, one word per cycle into the map RAM.
// Alloc reads from the lowest possibly free word, one map word per cycle through the single RAM port.
// Reset clears the engine and output registers, not the map RAM; its data is never used before the first init.
// A result waits in the output register while the next request is accepted.

module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       kind,
    input  logic [31:0]      mem_size_bytes,
    input  logic [31:0]      page_address,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      alloc_address,
    output logic [2:0]       status,
    output logic [CNT_W-1:0] free_count
);

    map_req_t    map_req;
    logic [31:0] map_rdata;
    logic        res_valid;
    logic        res_take;
    result_t     res;

    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg,   out_res_next;

    bpfa_map_ram u_map
    (
        .clk   (clk),
        .req   (map_req),
        .rdata (map_rdata)
    );

    bpfa_engine u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .mem_size_bytes (mem_size_bytes),
        .page_address   (page_address),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res),
        .map_req        (map_req),
        .map_rdata      (map_rdata)
    );

    // Load the output register when empty or drained this cycle
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign alloc_address = out_res_reg.addr;
    assign status        = out_res_reg.status;
    assign free_count    = out_res_reg.free_count;

`ifndef SYNTHESIS
    // An accepted request keeps the engine busy in the cycle after it is accepted
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("in_ready high right after an accepted request");

    // Only a successful request carries an address
    property p_addr_zero_on_fail;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DONE) |-> (alloc_address == '0);
    endproperty
    a_addr_zero_on_fail: assert property (p_addr_zero_on_fail)
        else $error("nonzero address with a failing status");

    // Addresses are page aligned
    property p_addr_aligned;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (alloc_address[PAGE_SHIFT-1:0] == '0);
    endproperty
    a_addr_aligned: assert property (p_addr_aligned)
        else $error("allocated address not page aligned");
`endif

endmodule
